@@ hdl/rmm2d_pkg.sv @@
// ----------------------------------------------------------------------------
// rmm2d_pkg: shared types and constants for the 2D sparse table block
// Table geometry, item kinds, status codes and the build/query sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none
package rmm2d_pkg;
    localparam int MaxRows   = 32;
    localparam int MaxCols   = 32;
    localparam int DataWidth = 32;
    localparam int RowLevels = $clog2(MaxRows) + 1;
    localparam int ColLevels = $clog2(MaxCols) + 1;
    localparam int TableSize = RowLevels * MaxRows * ColLevels * MaxCols;
    localparam int AddrW     = $clog2(TableSize);
    localparam int RowW      = $clog2(MaxRows);
    localparam int ColW      = $clog2(MaxCols);
    localparam int RlvW      = $clog2(RowLevels);
    localparam int ClvW      = $clog2(ColLevels);
    localparam int CntW      = 6;

    localparam logic       FuncLoad   = 1'b0;
    localparam logic       FuncQuery  = 1'b1;
    localparam logic [1:0] StatOk     = 2'd0;
    localparam logic [1:0] StatBounds = 2'd1;
    localparam logic [1:0] StatNoTbl  = 2'd2;
    localparam logic [1:0] CfgRows    = 2'd0;
    localparam logic [1:0] CfgCols    = 2'd1;
    localparam logic [1:0] CfgOp      = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BSTART,
        ST_BRD,
        ST_BWAIT,
        ST_BWR,
        ST_BNEXT,
        ST_QRD,
        ST_QWAIT,
        ST_OUT
    } state_t;

    function automatic logic [AddrW-1:0] cell_addr(input logic [RlvW-1:0] i,
            input logic [RowW-1:0] j, input logic [ClvW-1:0] k,
            input logic [ColW-1:0] t);
        cell_addr = AddrW'(((AddrW'(i) * MaxRows + AddrW'(j)) * ColLevels + AddrW'(k))
                           * MaxCols + AddrW'(t));
    endfunction

    function automatic logic [CntW-1:0] flog2(input logic [CntW-1:0] v);
        logic [CntW-1:0] r;
        r = '0;
        for (int b = 0; b < CntW; b++) begin
            if (v[b]) begin
                r = CntW'(b);
            end
        end
        flog2 = r;
    endfunction
endpackage
`default_nettype wire

@@ hdl/range_min_max_2d_sparse_table.sv @@
// ----------------------------------------------------------------------------
// range_min_max_2d_sparse_table: 2D sparse table range min/max
// Loads a signed matrix, builds power-of-two rectangle levels and answers
// rectangle min/max queries, all through one table memory and one comparator.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries load and query transactions, m_axis one result per query.
//   A load without tlast leaves the block idle and tready stays high, so
//   loads stream back to back. The load with tlast starts a build: a start
//   state, then per level entry ST_BNEXT alone for a level-0 cell (skipped),
//   two reads for an entry with row or column level 0 and four reads for
//   any other entry; each read holds the single memory port in ST_BRD and
//   is combined in ST_BWAIT, then ST_BWR writes the entry. The block returns
//   to idle after the last entry.
//   A query issues four reads (ST_QRD and ST_QWAIT each, one port), reduces
//   them on the shared comparator and presents the result in ST_OUT; the
//   next transaction is taken once the result has been accepted.
//   Errors (no table, bad bounds) present the result in the cycle after accept.
//   s_axis_tready is low while an item is in work and while the result
//   waits; a stalled receiver holds the block. Reset clears the built flag
//   and configuration (32, 32, min); table contents are undefined until
//   loaded; no clearing pass is run. The user writes configuration through
//   cfg_we/cfg_addr/cfg_wdata only while idle; the block does not enforce it.
`default_nettype none
module range_min_max_2d_sparse_table
    import rmm2d_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_addr,
    input  wire logic [5:0]  cfg_wdata,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // load_row, load_col, cell_value, row_low, row_high, col_low, col_high, pad
    input  wire logic [63:0] s_axis_tdata,
    input  wire logic        s_axis_tlast,   // load_last
    input  wire logic        s_axis_tuser,   // func
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // query_result, query_status, pad
    output logic [39:0]      m_axis_tdata
);
    logic [DataWidth-1:0] mem [TableSize];
    logic [DataWidth-1:0] rd_reg;

    state_t state_reg, state_next;
    logic [CntW-1:0] rows_reg, cols_reg, brows_reg, bcols_reg;
    logic op_reg, bop_reg, built_reg;
    logic [RlvW-1:0] i_reg;
    logic [RowW-1:0] j_reg;
    logic [ClvW-1:0] k_reg;
    logic [ColW-1:0] t_reg;
    logic [RowW-1:0] j2_reg;
    logic [ColW-1:0] t2_reg;
    logic [1:0] rn_reg, nrd_reg;
    logic [DataWidth-1:0] acc_reg, res_reg;
    logic [1:0] stat_reg;
    logic [CntW-1:0] logn_reg, logm_reg;

    logic [4:0] q_b, q_t, q_l, q_r;
    assign q_b = s_axis_tdata[42+:5];
    assign q_t = s_axis_tdata[47+:5];
    assign q_l = s_axis_tdata[52+:5];
    assign q_r = s_axis_tdata[57+:5];

    // query levels and second corners
    logic [RowW-1:0] qb2;
    logic [ColW-1:0] ql2;
    logic [CntW-1:0] lh, lw;
    always_comb begin
        lh  = flog2(CntW'(q_t - q_b) + 1'b1);
        lw  = flog2(CntW'(q_r - q_l) + 1'b1);
        qb2 = RowW'(CntW'(q_t) + 1'b1 - (CntW'(1) << lh));
        ql2 = ColW'(CntW'(q_r) + 1'b1 - (CntW'(1) << lw));
    end

    logic accept;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = (state_reg == ST_OUT);
    assign m_axis_tdata = {6'd0, stat_reg, res_reg};

    // shared comparator
    logic less, pick_rd;
    logic [DataWidth-1:0] red;
    assign less = $signed(rd_reg) < $signed(acc_reg);
    assign pick_rd = bop_reg ? !less && (rd_reg != acc_reg) : less;
    assign red = pick_rd ? rd_reg : acc_reg;

    // read address for read number rn
    logic [AddrW-1:0] raddr;
    always_comb begin
        raddr = '0;
        if (state_reg == ST_QRD) begin
            // query reads its own level at the four corners
            case (rn_reg)
                2'd0:    raddr = cell_addr(i_reg, j_reg, k_reg, t_reg);
                2'd1:    raddr = cell_addr(i_reg, j2_reg, k_reg, t_reg);
                2'd2:    raddr = cell_addr(i_reg, j_reg, k_reg, t2_reg);
                default: raddr = cell_addr(i_reg, j2_reg, k_reg, t2_reg);
            endcase
        end else if (i_reg == '0) begin
            case (rn_reg)
                2'd0:    raddr = cell_addr('0, j_reg, k_reg - 1'b1, t_reg);
                default: raddr = cell_addr('0, j_reg, k_reg - 1'b1, t2_reg);
            endcase
        end else begin
            case (rn_reg)
                2'd0:    raddr = cell_addr(i_reg - 1'b1, j_reg, k_reg, t_reg);
                2'd1:    raddr = cell_addr(i_reg - 1'b1, j2_reg, k_reg, t_reg);
                2'd2:    raddr = cell_addr(i_reg - 1'b1, j_reg, k_reg - 1'b1, t2_reg);
                default: raddr = cell_addr(i_reg - 1'b1, j2_reg, k_reg - 1'b1, t2_reg);
            endcase
        end
    end

    // clamped second offsets for current (i,j,k,t)
    logic [CntW:0] jo, to;
    logic [RowW-1:0] j2c;
    logic [ColW-1:0] t2c;
    always_comb begin
        jo = (CntW+1)'(j_reg) + ((i_reg == '0) ? '0 : ((CntW+1)'(1) << (i_reg - 1'b1)));
        to = (CntW+1)'(t_reg) + ((k_reg == '0) ? '0 : ((CntW+1)'(1) << (k_reg - 1'b1)));
        j2c = (jo > (CntW+1)'(brows_reg - 1'b1)) ? RowW'(brows_reg - 1'b1) : RowW'(jo);
        t2c = (to > (CntW+1)'(bcols_reg - 1'b1)) ? ColW'(bcols_reg - 1'b1) : ColW'(to);
    end

    logic last_t, last_k, last_j, last_i;
    assign last_t = (CntW'(t_reg) == bcols_reg - 1'b1);
    assign last_k = (CntW'(k_reg) == logm_reg);
    assign last_j = (CntW'(j_reg) == brows_reg - 1'b1);
    assign last_i = (CntW'(i_reg) == logn_reg);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_axis_tuser == FuncLoad) begin
                        state_next = s_axis_tlast ? ST_BSTART : ST_IDLE;
                    end else if (!built_reg || q_b > q_t || q_l > q_r ||
                                 CntW'(q_t) >= brows_reg || CntW'(q_r) >= bcols_reg) begin
                        state_next = ST_OUT;
                    end else begin
                        state_next = ST_QRD;
                    end
                end
            end
            ST_BSTART: state_next = ST_BNEXT;
            ST_BRD:    state_next = ST_BWAIT;
            ST_BWAIT:  state_next = (rn_reg == nrd_reg) ? ST_BWR : ST_BRD;
            ST_BWR: begin
                state_next = (last_t && last_k && last_j && last_i) ? ST_IDLE : ST_BNEXT;
            end
            ST_BNEXT: begin
                if (i_reg == '0 && k_reg == '0) begin
                    state_next = (last_t && last_k && last_j && last_i) ? ST_IDLE : ST_BNEXT;
                end else begin
                    state_next = ST_BRD;
                end
            end
            ST_QRD:    state_next = ST_QWAIT;
            ST_QWAIT:  state_next = (rn_reg == 2'd3) ? ST_OUT : ST_QRD;
            ST_OUT:    state_next = m_axis_tready ? ST_IDLE : ST_OUT;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            built_reg <= 1'b0;
            rows_reg  <= 6'd32;
            cols_reg  <= 6'd32;
            op_reg    <= 1'b0;
            brows_reg <= 6'd32;
            bcols_reg <= 6'd32;
            bop_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                case (cfg_addr)
                    CfgRows: rows_reg <= cfg_wdata;
                    CfgCols: cols_reg <= cfg_wdata;
                    CfgOp:   op_reg   <= cfg_wdata[0];
                    default: ;
                endcase
            end
            if (accept && s_axis_tuser == FuncLoad) begin
                built_reg <= 1'b0;
                if (s_axis_tlast) begin
                    brows_reg <= (rows_reg == '0) ? 6'd1 :
                                 (rows_reg > CntW'(MaxRows)) ? CntW'(MaxRows) : rows_reg;
                    bcols_reg <= (cols_reg == '0) ? 6'd1 :
                                 (cols_reg > CntW'(MaxCols)) ? CntW'(MaxCols) : cols_reg;
                    bop_reg   <= op_reg;
                end
            end
            if (state_reg == ST_BNEXT && i_reg == '0 && k_reg == '0 && last_t && last_j
                && last_k && last_i) begin
                built_reg <= 1'b1;
            end
            if (state_reg == ST_BWR && last_t && last_k && last_j && last_i) begin
                built_reg <= 1'b1;
            end
        end
    end

    // sequencer datapath and memory
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (accept && s_axis_tuser == FuncLoad) begin
                    mem[cell_addr('0, s_axis_tdata[0+:5], '0, s_axis_tdata[5+:5])]
                        <= s_axis_tdata[10+:32];
                end
                if (accept && s_axis_tuser == FuncQuery) begin
                    i_reg  <= RlvW'(lh);
                    k_reg  <= ClvW'(lw);
                    j_reg  <= q_b;
                    t_reg  <= q_l;
                    j2_reg <= qb2;
                    t2_reg <= ql2;
                    rn_reg <= 2'd0;
                    res_reg <= '0;
                    stat_reg <= !built_reg ? StatNoTbl : StatBounds;
                end
            end
            ST_BSTART: begin
                logn_reg <= flog2(brows_reg);
                logm_reg <= flog2(bcols_reg);
                i_reg <= '0; j_reg <= '0; k_reg <= '0; t_reg <= '0;
                rn_reg <= 2'd0;
            end
            ST_BNEXT: begin
                // skip level (0,0) entries; step to next when at (0,0)
                if (i_reg == '0 && k_reg == '0) begin
                    if (!last_t) t_reg <= t_reg + 1'b1;
                    else begin
                        t_reg <= '0;
                        if (!last_k) k_reg <= k_reg + 1'b1;
                        else begin
                            k_reg <= '0;
                            if (!last_j) j_reg <= j_reg + 1'b1;
                            else begin
                                j_reg <= '0;
                                i_reg <= i_reg + 1'b1;
                            end
                        end
                    end
                end
                j2_reg <= j2c;
                t2_reg <= t2c;
                rn_reg <= 2'd0;
                nrd_reg <= (i_reg == '0) ? 2'd1 : ((k_reg == '0) ? 2'd1 : 2'd3);
            end
            ST_BRD, ST_QRD: rd_reg <= mem[raddr];
            ST_BWAIT, ST_QWAIT: begin
                acc_reg <= (rn_reg == 2'd0) ? rd_reg : red;
                rn_reg <= rn_reg + 1'b1;
                if (state_reg == ST_QWAIT && rn_reg == 2'd3) begin
                    res_reg <= red;
                    stat_reg <= StatOk;
                end
            end
            ST_BWR: begin
                mem[cell_addr(i_reg, j_reg, k_reg, t_reg)] <= acc_reg;
                if (!last_t) t_reg <= t_reg + 1'b1;
                else begin
                    t_reg <= '0;
                    if (!last_k) k_reg <= k_reg + 1'b1;
                    else begin
                        k_reg <= '0;
                        if (!last_j) j_reg <= j_reg + 1'b1;
                        else begin
                            j_reg <= '0;
                            i_reg <= i_reg + 1'b1;
                        end
                    end
                end
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire
